### rtl/assert_macros.svh
// Assertion macros used by the checker file of the traffic flow classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define TFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tfc_pkg.sv
// Types and constants of the traffic flow classifier.
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int PCODE_W  = PORT_W + 1;
    localparam int FID_W    = 16;
    localparam int STATUS_W = 3;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 16;

    localparam logic [ADDR_W-1:0]  ADDR_ANY  = '0;
    localparam logic [PCODE_W-1:0] PORT_NONE = '0;

    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic MODE_CLASSIFY = 1'b0;
    localparam logic MODE_INSERT   = 1'b1;

    // Input transaction data, lowest field in the lowest bits.
    typedef struct packed {
        logic [5:0]        pad;
        logic [FID_W-1:0]  new_flow_id;
        logic              dst_port_given;
        logic [PORT_W-1:0] dst_port;
        logic              source_port_given;
        logic [PORT_W-1:0] source_port;
        logic [ADDR_W-1:0] dst_addr;
        logic [ADDR_W-1:0] source_addr;
    } t_in_data;

    // One filter entry; a port code carries the given flag above the port.
    typedef struct packed {
        logic [FID_W-1:0]   flow_id;
        logic [PCODE_W-1:0] dst_pcode;
        logic [PCODE_W-1:0] src_pcode;
        logic [ADDR_W-1:0]  secondary;
        logic [ADDR_W-1:0]  primary;
    } t_entry;

    function automatic logic [PCODE_W-1:0] port_code(input logic [PORT_W-1:0] port,
                                                     input logic given);
        port_code = given ? {1'b1, port} : PORT_NONE;
    endfunction

endpackage

`default_nettype wire

### rtl/traffic_flow_classifier.sv
// Traffic flow classifier top level: filter table, scan sequencer and stream ports.
`timescale 1ns / 1ps
`default_nettype none

// A transaction scans the filled table entries one after another through the single
// read port of the filter memory, then waits in S_FINISH until the output register
// is free; the input takes no new transaction until that result has been loaded.
// Reset (synchronous, active low) empties the table, sets gateway_side to 1 and
// drops any pending result; the table memory itself is not cleared.
module traffic_flow_classifier
    import tfc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Configuration write: bit 0 is gateway_side.
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [0:0]             i_cfg_data,
    // Input tdata, from bit 0 up: source address, destination address, source port,
    // source port given flag, destination port, destination port given flag,
    // new flow id, zero padding.
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire  [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Input tuser: mode.
    input  wire  [0:0]             i_s_axis_tuser,
    // Output tdata: flow_id.
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Output tuser: status.
    output logic [STATUS_W-1:0]    o_m_axis_tuser
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Filter table: one write port for inserts and one registered read port for the scan.
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    t_state          r_state;
    logic            r_gateway_side;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic            r_pend;
    logic            r_hit_exact;
    logic            r_hit_addr;
    logic            r_hit_any;
    logic            r_m_valid;
    logic [FID_W-1:0]    r_m_fid;
    logic [STATUS_W-1:0] r_m_status;

    // Search key of the transaction in progress.
    logic                r_mode;
    logic [ADDR_W-1:0]   r_pkey;
    logic [ADDR_W-1:0]   r_skey;
    logic [PCODE_W-1:0]  r_sp;
    logic [PCODE_W-1:0]  r_dp;
    logic [FID_W-1:0]    r_nfid;
    logic [FID_W-1:0]    r_fid_exact;
    logic [FID_W-1:0]    r_fid_addr;
    logic [FID_W-1:0]    r_fid_any;

    t_in_data  w_in;
    logic      w_in_accept;
    logic      w_pri_eq;
    logic      w_sec_eq;
    logic      w_sec_any;
    logic      w_ports_eq;
    logic      w_ports_none;
    logic      w_match_exact;
    logic      w_match_addr;
    logic      w_match_any;
    logic      w_hit;
    logic [FID_W-1:0] w_hit_fid;
    logic      w_full;
    logic      w_out_free;
    logic      w_do_finish;
    logic      w_insert;
    t_entry    w_new_entry;

    assign w_in        = t_in_data'(i_s_axis_tdata);
    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_fid;
    assign o_m_axis_tuser  = r_m_status;

    // The one comparator bank: it checks the entry read in the previous cycle against
    // all three search patterns at once, so one sweep settles every pass.
    assign w_pri_eq      = (r_rd_data.primary == r_pkey);
    assign w_sec_eq      = (r_rd_data.secondary == r_skey);
    assign w_sec_any     = (r_rd_data.secondary == ADDR_ANY);
    assign w_ports_eq    = (r_rd_data.src_pcode == r_sp) && (r_rd_data.dst_pcode == r_dp);
    assign w_ports_none  = (r_rd_data.src_pcode == PORT_NONE) &&
                           (r_rd_data.dst_pcode == PORT_NONE);
    assign w_match_exact = w_pri_eq && w_sec_eq && w_ports_eq;
    assign w_match_addr  = w_pri_eq && w_sec_eq && w_ports_none;
    assign w_match_any   = w_pri_eq && w_sec_any && w_ports_none;

    // Pass priority: an exact match wins over an address match, which wins over
    // the wildcard address; within a pass the earliest entry was kept.
    assign w_hit = r_hit_exact || r_hit_addr || r_hit_any;
    always_comb begin
        priority if (r_hit_exact) begin
            w_hit_fid = r_fid_exact;
        end else if (r_hit_addr) begin
            w_hit_fid = r_fid_addr;
        end else begin
            w_hit_fid = r_fid_any;
        end
    end

    assign w_full      = (r_count == FULL_COUNT);
    assign w_out_free  = !r_m_valid || i_m_axis_tready;
    assign w_do_finish = (r_state == S_FINISH) && w_out_free;
    assign w_insert    = w_do_finish && (r_mode == MODE_INSERT) && !w_hit && !w_full;

    assign w_new_entry = '{flow_id:   r_nfid,
                           dst_pcode: r_dp,
                           src_pcode: r_sp,
                           secondary: r_skey,
                           primary:   r_pkey};

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_mem[r_count[IW-1:0]] <= w_new_entry;
        end
        r_rd_data <= r_mem[r_idx[IW-1:0]];
    end

    // Search key capture and per-pass flow ids.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_mode <= i_s_axis_tuser[0];
            r_pkey <= r_gateway_side ? w_in.dst_addr : w_in.source_addr;
            r_skey <= r_gateway_side ? w_in.source_addr : w_in.dst_addr;
            r_sp   <= port_code(w_in.source_port, w_in.source_port_given);
            r_dp   <= port_code(w_in.dst_port, w_in.dst_port_given);
            r_nfid <= w_in.new_flow_id;
        end
        if (r_pend) begin
            if (w_match_exact && !r_hit_exact) begin
                r_fid_exact <= r_rd_data.flow_id;
            end
            if (w_match_addr && !r_hit_addr) begin
                r_fid_addr <= r_rd_data.flow_id;
            end
            if (w_match_any && !r_hit_any) begin
                r_fid_any <= r_rd_data.flow_id;
            end
        end
    end

    // Sequencer, table fill count, configuration and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_gateway_side <= 1'b1;
            r_count        <= '0;
            r_idx          <= '0;
            r_pend         <= 1'b0;
            r_hit_exact    <= 1'b0;
            r_hit_addr     <= 1'b0;
            r_hit_any      <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_gateway_side <= i_cfg_data[0];
            end
            // A result that leaves while the next one is loaded keeps valid high.
            if (r_m_valid && i_m_axis_tready && !w_do_finish) begin
                r_m_valid <= 1'b0;
            end

            if (r_pend) begin
                r_hit_exact <= r_hit_exact || w_match_exact;
                r_hit_addr  <= r_hit_addr || w_match_addr;
                r_hit_any   <= r_hit_any || w_match_any;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    if (w_in_accept) begin
                        r_hit_exact <= 1'b0;
                        r_hit_addr  <= 1'b0;
                        r_hit_any   <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // One read per cycle; the compare of an entry follows its read.
                    if (r_idx < r_count) begin
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                        if (r_mode == MODE_CLASSIFY) begin
                            r_m_status <= w_hit ? ST_HIT : ST_MISS;
                            r_m_fid    <= w_hit ? w_hit_fid : '0;
                        end else if (w_hit) begin
                            r_m_status <= ST_DUPLICATE;
                            r_m_fid    <= w_hit_fid;
                        end else if (w_full) begin
                            r_m_status <= ST_FULL;
                            r_m_fid    <= '0;
                        end else begin
                            r_m_status <= ST_INSERTED;
                            r_m_fid    <= '0;
                            r_count    <= r_count + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/tfc_checker.sv
// Port-level checker of the traffic flow classifier and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tfc_checker
    import tfc_pkg::*;
(
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_s_axis_tvalid,
    input wire                    o_s_axis_tready,
    input wire                    o_m_axis_tvalid,
    input wire                    i_m_axis_tready,
    input wire [OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire [STATUS_W-1:0]     o_m_axis_tuser
);

    // A stalled result keeps its valid and its payload.
    `TFC_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // The block works on one transaction at a time.
    `TFC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "input ready right after acceptance")

    // Only defined status codes are produced.
    `TFC_ASSERT(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid |-> o_m_axis_tuser == ST_HIT || o_m_axis_tuser == ST_MISS || o_m_axis_tuser == ST_INSERTED || o_m_axis_tuser == ST_DUPLICATE || o_m_axis_tuser == ST_FULL, "undefined status")

    // Without a matching entry the flow id reads zero.
    `TFC_ASSERT(a_fid_zero, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == ST_MISS || o_m_axis_tuser == ST_INSERTED || o_m_axis_tuser == ST_FULL) |-> o_m_axis_tdata == '0, "nonzero flow id without a hit")

endmodule

bind traffic_flow_classifier tfc_checker u_tfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the traffic flow classifier: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import tfc_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [ADDR_W-1:0] HOST_A = 32'h0A00_0001;
    localparam logic [ADDR_W-1:0] HOST_B = 32'h0A00_0002;
    localparam logic [ADDR_W-1:0] GW_A   = 32'hC0A8_0001;
    localparam logic [ADDR_W-1:0] GW_B   = 32'hC0A8_0002;
    localparam logic [ADDR_W-1:0] ALL_1  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FID_W-1:0]    flow_id;
    } t_verdict;

    // One directed transaction; typed rows carry their own expected verdict.
    typedef struct packed {
        t_in_data pkt;
        logic     mode;
        logic     typed;
        t_verdict want;
    } t_dir_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [0:0]            cfg_data = 1'b0;
    logic                  pkt_valid = 1'b0;
    t_in_data              pkt_data = '0;
    logic [0:0]            pkt_mode = MODE_CLASSIFY;
    logic                  res_ready = 1'b0;

    wire                   o_cfg_ready;
    wire                   o_s_axis_tready;
    wire                   o_m_axis_tvalid;
    wire [OUT_TDATA_W-1:0] o_m_axis_tdata;
    wire [STATUS_W-1:0]    o_m_axis_tuser;

    // Mirror of the filter table and of the key-side register.
    logic [ADDR_W-1:0]  flt_primary   [TABLE_DEPTH];
    logic [ADDR_W-1:0]  flt_secondary [TABLE_DEPTH];
    logic [PCODE_W-1:0] flt_src_pcode [TABLE_DEPTH];
    logic [PCODE_W-1:0] flt_dst_pcode [TABLE_DEPTH];
    logic [FID_W-1:0]   flt_flow      [TABLE_DEPTH];
    int                 flt_count;
    logic               side_dst;

    t_verdict           flow_verdict_q [$];
    t_in_data           packet_log [$];
    t_dir_row           dir_rows [$];
    logic [ADDR_W-1:0]  addr_pool [8];
    logic [PORT_W-1:0]  port_pool [4];
    int                 pkt_count = 0;
    int                 fault_count = 0;

    traffic_flow_classifier #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (pkt_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (pkt_data),
        .i_s_axis_tuser  (pkt_mode),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Both sides run without idling while this window of transactions passes.
    function automatic logic calm_window();
        return (pkt_count >= 700 && pkt_count < 1000);
    endfunction

    // Three-pass lookup in insertion order, then the table update an insert causes.
    function automatic t_verdict predict_packet(input t_in_data d, input logic m);
        logic [ADDR_W-1:0]  pkey;
        logic [ADDR_W-1:0]  skey;
        logic [ADDR_W-1:0]  want_s;
        logic [PCODE_W-1:0] sp;
        logic [PCODE_W-1:0] dp;
        logic [PCODE_W-1:0] want_sp;
        logic [PCODE_W-1:0] want_dp;
        logic               hit;
        logic [FID_W-1:0]   fid;
        t_verdict           v;
        pkey = side_dst ? d.dst_addr : d.source_addr;
        skey = side_dst ? d.source_addr : d.dst_addr;
        sp   = d.source_port_given ? {1'b1, d.source_port} : PORT_NONE;
        dp   = d.dst_port_given ? {1'b1, d.dst_port} : PORT_NONE;
        hit  = 1'b0;
        fid  = '0;
        for (int pass = 0; pass < 3; pass++) begin
            want_s  = (pass == 2) ? ADDR_ANY : skey;
            want_sp = (pass == 0) ? sp : PORT_NONE;
            want_dp = (pass == 0) ? dp : PORT_NONE;
            for (int i = 0; i < flt_count; i++) begin
                if (!hit && flt_primary[i] == pkey && flt_secondary[i] == want_s &&
                    flt_src_pcode[i] == want_sp && flt_dst_pcode[i] == want_dp) begin
                    hit = 1'b1;
                    fid = flt_flow[i];
                end
            end
        end
        v.flow_id = '0;
        if (m == MODE_CLASSIFY) begin
            v.status = hit ? ST_HIT : ST_MISS;
            if (hit) begin
                v.flow_id = fid;
            end
        end else if (hit) begin
            // A hit in any pass makes the insert a duplicate, even on a full table.
            v.status  = ST_DUPLICATE;
            v.flow_id = fid;
        end else if (flt_count >= TABLE_DEPTH) begin
            v.status = ST_FULL;
        end else begin
            flt_primary[flt_count]   = pkey;
            flt_secondary[flt_count] = skey;
            flt_src_pcode[flt_count] = sp;
            flt_dst_pcode[flt_count] = dp;
            flt_flow[flt_count]      = d.new_flow_id;
            flt_count++;
            v.status = ST_INSERTED;
        end
        return v;
    endfunction

    function automatic t_dir_row mk_row(input logic mode, input logic [ADDR_W-1:0] src,
                                        input logic [ADDR_W-1:0] dst,
                                        input logic [PORT_W-1:0] sp, input logic spg,
                                        input logic [PORT_W-1:0] dp, input logic dpg,
                                        input logic [FID_W-1:0] fid, input logic typed,
                                        input logic [STATUS_W-1:0] st,
                                        input logic [FID_W-1:0] fl);
        t_dir_row r;
        r                       = '0;
        r.pkt.source_addr       = src;
        r.pkt.dst_addr          = dst;
        r.pkt.source_port       = sp;
        r.pkt.source_port_given = spg;
        r.pkt.dst_port          = dp;
        r.pkt.dst_port_given    = dpg;
        r.pkt.new_flow_id       = fid;
        r.mode                  = mode;
        r.typed                 = typed;
        r.want.status           = st;
        r.want.flow_id          = fl;
        return r;
    endfunction

    function automatic void add_row(input t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Mostly packets built from small address and port pools, so that entries get hit;
    // replays of earlier transactions reach exact matches, the rest is wide noise.
    function automatic void draw_packet(output t_in_data d, output logic m);
        int roll;
        roll = $urandom_range(99);
        d    = '0;
        m    = ($urandom_range(99) < 30) ? MODE_INSERT : MODE_CLASSIFY;
        if (roll < 15) begin
            d.source_addr       = $urandom;
            d.dst_addr          = $urandom;
            d.source_port       = PORT_W'($urandom_range(16'hFFFF));
            d.dst_port          = PORT_W'($urandom_range(16'hFFFF));
            d.source_port_given = 1'($urandom_range(1));
            d.dst_port_given    = 1'($urandom_range(1));
            d.new_flow_id       = FID_W'($urandom_range(16'hFFFF));
        end else if (roll < 45 && packet_log.size() > 0) begin
            d = packet_log[$urandom_range(packet_log.size() - 1)];
            if ($urandom_range(3) == 0) begin
                d.source_port_given = 1'b0;
            end
            if ($urandom_range(3) == 0) begin
                d.dst_port_given = 1'b0;
            end
            d.new_flow_id = FID_W'($urandom_range(16'hFFFF));
        end else begin
            d.source_addr       = addr_pool[$urandom_range(7)];
            d.dst_addr          = addr_pool[$urandom_range(7)];
            d.source_port       = ($urandom_range(1) == 1) ? port_pool[$urandom_range(3)] :
                                  PORT_W'($urandom_range(16'hFFFF));
            d.dst_port          = port_pool[$urandom_range(3)];
            d.source_port_given = 1'($urandom_range(1));
            d.dst_port_given    = 1'($urandom_range(1));
            d.new_flow_id       = FID_W'($urandom_range(16'hFFFF));
            // Wildcard secondary with no ports: the third lookup pass.
            if ($urandom_range(4) == 0) begin
                if (side_dst) begin
                    d.source_addr = ADDR_ANY;
                end else begin
                    d.dst_addr = ADDR_ANY;
                end
                d.source_port_given = 1'b0;
                d.dst_port_given    = 1'b0;
            end
        end
    endfunction

    // Offers one transaction and leaves tvalid high after acceptance, so that the next
    // call can follow back to back.
    task automatic offer_packet(input t_in_data d, input logic m, input logic typed,
                                input t_verdict want);
        t_verdict got;
        if (!calm_window() && $urandom_range(99) < 8) begin
            pkt_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        pkt_valid <= 1'b1;
        pkt_data  <= d;
        pkt_mode  <= m;
        do @(posedge clk); while (!o_s_axis_tready);
        got = predict_packet(d, m);
        flow_verdict_q.insert(flow_verdict_q.size(), typed ? want : got);
        packet_log.insert(packet_log.size(), d);
        if (packet_log.size() > 256) begin
            void'(packet_log.pop_front());
        end
        pkt_count++;
    endtask

    task automatic run_traffic(input int n);
        t_in_data d;
        logic     m;
        for (int k = 0; k < n; k++) begin
            draw_packet(d, m);
            offer_packet(d, m, 1'b0, '0);
        end
        pkt_valid <= 1'b0;
    endtask

    task automatic settle(input int extra);
        while (flow_verdict_q.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Key-side register write, only once the block has drained.
    task automatic write_side(input logic v);
        settle(4);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        side_dst  = v;
    endtask

    task automatic log_fault(input string msg);
        if (fault_count < 10) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        fault_count++;
    endtask

    // Result checker: every output transaction against the oldest expectation.
    always @(posedge clk) begin
        t_verdict exp_v;
        if (rst_n && o_m_axis_tvalid && res_ready) begin
            if (flow_verdict_q.size() == 0) begin
                log_fault($sformatf("unexpected result status=%0d flow_id=%h",
                                    o_m_axis_tuser, o_m_axis_tdata));
            end else begin
                exp_v = flow_verdict_q.pop_front();
                if (o_m_axis_tuser !== exp_v.status || o_m_axis_tdata !== exp_v.flow_id) begin
                    log_fault($sformatf("status exp %0d got %0d, flow_id exp %h got %h",
                                        exp_v.status, o_m_axis_tuser,
                                        exp_v.flow_id, o_m_axis_tdata));
                end
            end
        end
    end

    // Receiver: random back-pressure, a calm window, and one long hold-off that lets
    // the block back up and stall its input.
    initial begin
        int  hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else if (!hold_done && pkt_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_ready <= 1'b0;
            end else if (calm_window()) begin
                res_ready <= 1'b1;
            end else begin
                res_ready <= ($urandom_range(99) >= 8);
            end
        end
    end

    // Watchdog: too long without any transaction on any channel ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (pkt_valid && o_s_axis_tready) || (o_m_axis_tvalid && res_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("traffic_flow_classifier verification failed");
        $finish;
    end

    initial begin
        flt_count = 0;
        side_dst  = 1'b1;
        addr_pool[0] = ADDR_ANY;
        addr_pool[1] = ALL_1;
        for (int i = 2; i < 8; i++) begin
            addr_pool[i] = $urandom;
        end
        port_pool[0] = '0;
        port_pool[1] = 16'hFFFF;
        port_pool[2] = PORT_W'($urandom_range(16'hFFFF));
        port_pool[3] = PORT_W'($urandom_range(16'hFFFF));

        // After reset the destination address is the primary key.
        add_row(mk_row(MODE_CLASSIFY, ALL_1, ALL_1, 16'hFFFF, 1, 16'hFFFF, 1,
                       16'hFFFF, 1, ST_MISS, 16'h0000));
        add_row(mk_row(MODE_INSERT, HOST_A, GW_A, 16'hFFFF, 1, 16'h0000, 1,
                       16'h1234, 1, ST_INSERTED, 16'h0000));
        add_row(mk_row(MODE_INSERT, HOST_A, GW_A, 0, 0, 0, 0, 16'h0002, 0, 0, 0));
        add_row(mk_row(MODE_INSERT, ADDR_ANY, GW_A, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
        // Exact match, port-wildcard match and address-wildcard match.
        add_row(mk_row(MODE_CLASSIFY, HOST_A, GW_A, 16'hFFFF, 1, 0, 1, 0, 0, 0, 0));
        add_row(mk_row(MODE_CLASSIFY, HOST_A, GW_A, 16'h0001, 1, 0, 1, 0, 0, 0, 0));
        add_row(mk_row(MODE_CLASSIFY, HOST_B, GW_A, 16'h0001, 1, 16'h0002, 1,
                       0, 0, 0, 0));
        add_row(mk_row(MODE_CLASSIFY, HOST_A, GW_B, 0, 0, 0, 0, 0, 0, 0, 0));
        // Port values without the given flag must be ignored.
        add_row(mk_row(MODE_CLASSIFY, HOST_A, GW_A, 16'hFFFF, 0, 16'hFFFF, 0,
                       0, 0, 0, 0));
        add_row(mk_row(MODE_CLASSIFY, HOST_A, GW_A, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0));
        // Duplicates through an exact hit and through the address wildcard.
        add_row(mk_row(MODE_INSERT, HOST_A, GW_A, 16'hFFFF, 1, 0, 1, 16'h5555,
                       0, 0, 0));
        add_row(mk_row(MODE_INSERT, HOST_B, GW_A, 0, 0, 0, 0, 16'h7777, 0, 0, 0));
        add_row(mk_row(MODE_INSERT, ALL_1, ALL_1, 0, 0, 16'hFFFF, 1, 16'h0000,
                       0, 0, 0));
        add_row(mk_row(MODE_CLASSIFY, ALL_1, ALL_1, 16'h1234, 0, 16'hFFFF, 1,
                       0, 0, 0, 0));
        add_row(mk_row(MODE_CLASSIFY, ADDR_ANY, ADDR_ANY, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_row(MODE_INSERT, ADDR_ANY, ADDR_ANY, 0, 0, 0, 0, 16'h8001,
                       0, 0, 0));
        add_row(mk_row(MODE_CLASSIFY, HOST_B, ADDR_ANY, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            offer_packet(dir_rows[i].pkt, dir_rows[i].mode, dir_rows[i].typed,
                         dir_rows[i].want);
        end
        pkt_valid <= 1'b0;

        // Random phases alternate the key side; the table fills in the first of them.
        write_side(1'b0);
        run_traffic(450);
        write_side(1'b1);
        run_traffic(450);
        write_side(1'b0);
        run_traffic(350);
        write_side(1'b1);
        run_traffic(350);

        settle(80);
        if (fault_count == 0 && flow_verdict_q.size() == 0) begin
            $display("traffic_flow_classifier verification clean");
        end else begin
            $display("traffic_flow_classifier verification failed");
        end
        $finish;
    end

endmodule
